// ===== sv/edfts_pkg.sv =====
// ----------------------------------------------------------------------------
// edfts_pkg
// shared types and constants of the deadline task table scheduler
// ----------------------------------------------------------------------------
package edfts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        OP_REGISTER  = 2'd0,
        OP_MARK_DONE = 2'd1,
        OP_RELEASE   = 2'd2,
        OP_PICK      = 2'd3
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  task_id;
        logic [31:0] period;
        logic [31:0] release_time;
        logic [7:0]  priority_number;
        logic        start_done;
        logic [31:0] now_tick;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  slot_index;
        logic        table_full;
        logic [15:0] released_mask;
        logic        found;
        logic [7:0]  next_priority;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] period;
        logic [31:0] release_tick;
        logic        done;
        logic [7:0]  prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== sv/edfts_ram.sv =====
// ----------------------------------------------------------------------------
// edfts_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module edfts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/edfts_engine.sv =====
// ----------------------------------------------------------------------------
// edfts_engine
// task table in ram, register / mark done / release / pick sequencer
// ----------------------------------------------------------------------------
module edfts_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  edfts_pkg::t_in_item i_cmd,
    input  logic                i_ack,
    output logic                o_done,
    output edfts_pkg::t_out_item o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [edfts_pkg::CNT_W-1:0]  r_fill, n_fill;
    logic [edfts_pkg::SLOT_W-1:0] r_rd_addr, n_rd_addr;
    logic                        r_rd_vld, n_rd_vld;
    logic [edfts_pkg::SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic                        r_dv, n_dv;
    logic [31:0]                 r_dist, n_dist;
    logic [7:0]                  r_dprio, n_dprio;
    logic                        r_have, n_have;
    logic [31:0]                 r_best, n_best;
    logic [7:0]                  r_bp, n_bp;
    logic [15:0]                 r_mask, n_mask;
    edfts_pkg::t_out_item        r_res, n_res;

    logic                        we;
    logic [edfts_pkg::SLOT_W-1:0] waddr;
    edfts_pkg::t_entry           wdata;
    edfts_pkg::t_entry           rd;
    logic [edfts_pkg::ENTRY_W-1:0] rdata;
    logic                        issue;
    logic                        last;
    logic [31:0]                 due;

    edfts_ram #(
        .WIDTH (edfts_pkg::ENTRY_W),
        .DEPTH (edfts_pkg::MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (rdata)
    );

    assign rd    = edfts_pkg::t_entry'(rdata);
    assign due   = rd.release_tick + rd.period;
    assign issue = (edfts_pkg::CNT_W'(r_rd_addr) < r_fill);
    assign last  = ((edfts_pkg::CNT_W'(r_rd_addr) + edfts_pkg::CNT_W'(1)) >= r_fill);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_rd_addr = r_rd_addr;
        n_rd_vld  = 1'b0;
        n_rd_slot = r_rd_slot;
        n_dv      = 1'b0;
        n_dist    = r_dist;
        n_dprio   = r_dprio;
        n_have    = r_have;
        n_best    = r_best;
        n_bp      = r_bp;
        n_mask    = r_mask;
        n_res     = r_res;
        we        = 1'b0;
        waddr     = r_rd_slot;
        wdata     = rd;

        // read data from the previous cycle, modify and write back
        if (r_rd_vld) begin
            case (i_cmd.operation)
                edfts_pkg::OP_MARK_DONE: begin
                    if (rd.id == i_cmd.task_id) begin
                        we         = 1'b1;
                        wdata.done = 1'b1;
                    end
                end
                edfts_pkg::OP_RELEASE: begin
                    if (rd.done && (due <= i_cmd.now_tick)) begin
                        we                 = 1'b1;
                        wdata.done         = 1'b0;
                        wdata.release_tick = i_cmd.now_tick;
                        n_mask             = r_mask | (16'(1) << r_rd_slot);
                    end
                end
                edfts_pkg::OP_PICK: begin
                    n_dv    = ~rd.done;
                    n_dist  = due - i_cmd.now_tick;
                    n_dprio = rd.prio;
                end
                default: begin
                end
            endcase
        end

        // distance compare, later slot wins ties
        if (r_dv && (!r_have || (r_dist <= r_best))) begin
            n_have = 1'b1;
            n_best = r_dist;
            n_bp   = r_dprio;
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res     = '0;
                    n_mask    = '0;
                    n_have    = 1'b0;
                    n_bp      = '0;
                    n_rd_addr = '0;
                    if (i_cmd.operation == edfts_pkg::OP_REGISTER) begin
                        n_state = S_DONE;
                        if (r_fill == edfts_pkg::CNT_W'(edfts_pkg::MAX_TASKS)) begin
                            n_res.table_full = 1'b1;
                        end else begin
                            we                 = 1'b1;
                            waddr              = r_fill[edfts_pkg::SLOT_W-1:0];
                            wdata.id           = i_cmd.task_id;
                            wdata.period       = i_cmd.period;
                            wdata.release_tick = i_cmd.release_time;
                            wdata.done         = i_cmd.start_done;
                            wdata.prio         = i_cmd.priority_number;
                            n_res.slot_index   = 4'(r_fill);
                            n_fill             = r_fill + edfts_pkg::CNT_W'(1);
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_rd_vld  = issue;
                n_rd_slot = r_rd_addr;
                if (last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_addr = r_rd_addr + edfts_pkg::SLOT_W'(1);
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !r_dv) begin
                    n_state = S_DONE;
                    if (i_cmd.operation == edfts_pkg::OP_RELEASE) begin
                        n_res.released_mask = r_mask;
                    end else if (i_cmd.operation == edfts_pkg::OP_PICK) begin
                        n_res.found         = r_have;
                        n_res.next_priority = r_bp;
                    end
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_rd_vld <= n_rd_vld;
            r_dv     <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_rd_slot <= n_rd_slot;
        r_dist    <= n_dist;
        r_dprio   <= n_dprio;
        r_have    <= n_have;
        r_best    <= n_best;
        r_bp      <= n_bp;
        r_mask    <= n_mask;
        r_res     <= n_res;
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

// ===== sv/edf_task_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// edf_task_table_scheduler
// earliest deadline first task table with valid/stall item channels
// ----------------------------------------------------------------------------
// The block holds up to MAX_TASKS periodic tasks in a single ram and handles
// one item at a time. Mark done, release and pick items read every
// registered slot, one slot per cycle through the ram port, and mark done
// and release items write back the slots that they change. The next item is
// accepted as soon as the previous result sits in the output register.
module edf_task_table_scheduler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  edfts_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output edfts_pkg::t_out_item o_out_item
);

    logic                 r_busy;
    logic                 r_start;
    edfts_pkg::t_in_item  r_in;
    logic                 r_out_vld;
    edfts_pkg::t_out_item r_out;

    logic                 in_acc;
    logic                 eng_done;
    logic                 eng_ack;
    edfts_pkg::t_out_item eng_res;

    assign in_acc  = i_in_valid && !r_busy;
    assign eng_ack = eng_done && (!r_out_vld || !i_out_stall);

    edfts_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_cmd   (r_in),
        .i_ack   (eng_ack),
        .o_done  (eng_done),
        .o_res   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_start   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_start <= in_acc;
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (eng_ack) begin
                r_busy <= 1'b0;
            end
            if (eng_ack) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_item;
        end
        if (eng_ack) begin
            r_out <= eng_res;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== dv/edf_task_table_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_task_table_scheduler_tb
// self-checking testbench for the deadline task table scheduler
// ----------------------------------------------------------------------------
// Sends register, mark done, release and pick items through the valid/stall
// input channel. Each result is checked against a table model kept in the
// bench, which holds ids, periods, release ticks, done flags and priorities.
// A short directed opening fills the table and covers the corner cases:
// empty table, full table, all-zero and all-ones fields, duplicate ids,
// deadline ties and wrapped sums. Random traffic follows on an advancing
// tick count. Three idling mixes are run on both channels, with one long
// output hold-off and one input pause that waits for all results to drain.
// ----------------------------------------------------------------------------
module edf_task_table_scheduler_tb;

    localparam int RANDOM_OPS   = 850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AT      = 760;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 100;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    edfts_pkg::t_in_item  in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    edfts_pkg::t_out_item out_item;

    edfts_pkg::t_entry task_tbl [edfts_pkg::MAX_TASKS];
    logic              task_used [edfts_pkg::MAX_TASKS];
    int                task_fill      = 0;
    logic [7:0]        last_pick_prio = '0;

    edfts_pkg::t_in_item  task_ops_q [$];
    edfts_pkg::t_out_item sched_results_q [$];

    int   total_ops      = 0;
    int   ops_accepted   = 0;
    int   results_seen   = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   hold_left      = 0;
    logic held_off       = 1'b0;

    edf_task_table_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #10 i_clk = ~i_clk;

    function automatic edfts_pkg::t_in_item sched_op(edfts_pkg::t_op kind, logic [7:0] id,
                                                     logic [31:0] per, logic [31:0] rel,
                                                     logic [7:0] prio, logic sdone,
                                                     logic [31:0] now);
        edfts_pkg::t_in_item op;
        op.operation       = kind;
        op.task_id         = id;
        op.period          = per;
        op.release_time    = rel;
        op.priority_number = prio;
        op.start_done      = sdone;
        op.now_tick        = now;
        return op;
    endfunction

    function automatic edfts_pkg::t_out_item sched_apply(edfts_pkg::t_in_item op);
        edfts_pkg::t_out_item res;
        logic [31:0]          due;
        logic [31:0]          gap;
        logic [31:0]          best;
        logic                 have;
        res  = '0;
        best = '0;
        have = 1'b0;
        case (op.operation)
            edfts_pkg::OP_REGISTER: begin
                if (task_fill >= edfts_pkg::MAX_TASKS) begin
                    res.table_full = 1'b1;
                end else begin
                    task_used[task_fill]             = 1'b1;
                    task_tbl[task_fill].id           = op.task_id;
                    task_tbl[task_fill].period       = op.period;
                    task_tbl[task_fill].release_tick = op.release_time;
                    task_tbl[task_fill].done         = op.start_done;
                    task_tbl[task_fill].prio         = op.priority_number;
                    res.slot_index                   = 4'(task_fill);
                    task_fill++;
                end
            end
            edfts_pkg::OP_MARK_DONE: begin
                for (int s = 0; s < edfts_pkg::MAX_TASKS; s++) begin
                    if (task_used[s] && task_tbl[s].id == op.task_id)
                        task_tbl[s].done = 1'b1;
                end
            end
            edfts_pkg::OP_RELEASE: begin
                for (int s = 0; s < edfts_pkg::MAX_TASKS; s++) begin
                    if (task_used[s] && task_tbl[s].done) begin
                        due = task_tbl[s].release_tick + task_tbl[s].period;
                        if (due <= op.now_tick) begin
                            task_tbl[s].done         = 1'b0;
                            task_tbl[s].release_tick = op.now_tick;
                            if (s < 16)
                                res.released_mask[s] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // scan from the top slot so the latest registered task wins ties
                for (int s = edfts_pkg::MAX_TASKS - 1; s >= 0; s--) begin
                    if (task_used[s] && !task_tbl[s].done) begin
                        gap = task_tbl[s].period + task_tbl[s].release_tick - op.now_tick;
                        if (!have || gap < best) begin
                            have              = 1'b1;
                            best              = gap;
                            res.next_priority = task_tbl[s].prio;
                        end
                    end
                end
                res.found      = have;
                last_pick_prio = res.next_priority;
            end
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        logic                offer;
        edfts_pkg::t_in_item next_item;
        int                  idle_pct;
        offer     = in_valid;
        next_item = in_item;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                sched_results_q.push_back(sched_apply(in_item));
                ops_accepted++;
                offer = 1'b0;
            end
            if (ops_accepted < total_ops / 3)
                idle_pct = 34;
            else if (ops_accepted < 2 * total_ops / 3)
                idle_pct = 83;
            else
                idle_pct = 0;
            if (!offer && task_ops_q.size() != 0
                    && !(ops_accepted == PAUSE_AT && sched_results_q.size() != 0)
                    && $urandom_range(99) >= idle_pct) begin
                next_item = task_ops_q.pop_front();
                offer     = 1'b1;
            end
        end
        in_valid <= offer;
        in_item  <= next_item;
    end

    // monitor
    always @(posedge i_clk) begin
        edfts_pkg::t_out_item want;
        logic                 hold;
        int                   idle_pct;
        hold = 1'b0;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (sched_results_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %p", out_item));
                end else begin
                    want = sched_results_q.pop_front();
                    if (out_item.slot_index !== want.slot_index)
                        flag_mismatch($sformatf("result %0d slot_index %0h want %0h",
                            results_seen, out_item.slot_index, want.slot_index));
                    if (out_item.table_full !== want.table_full)
                        flag_mismatch($sformatf("result %0d table_full %0h want %0h",
                            results_seen, out_item.table_full, want.table_full));
                    if (out_item.released_mask !== want.released_mask)
                        flag_mismatch($sformatf("result %0d released_mask %0h want %0h",
                            results_seen, out_item.released_mask, want.released_mask));
                    if (out_item.found !== want.found)
                        flag_mismatch($sformatf("result %0d found %0h want %0h",
                            results_seen, out_item.found, want.found));
                    if (out_item.next_priority !== want.next_priority)
                        flag_mismatch($sformatf("result %0d next_priority %0h want %0h",
                            results_seen, out_item.next_priority, want.next_priority));
                end
            end
            if (!held_off && results_seen == HOLD_AT) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (results_seen < total_ops / 3)
                idle_pct = 83;
            else if (results_seen < 2 * total_ops / 3)
                idle_pct = 34;
            else
                idle_pct = 0;
            if (hold_left > 0) begin
                hold_left--;
                hold = 1'b1;
            end else begin
                hold = $urandom_range(99) < idle_pct;
            end
        end
        out_stall <= hold;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sched_results_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        edfts_pkg::t_in_item op;
        logic [7:0]          known_ids [$];
        logic [31:0]         tick;
        logic [31:0]         per;
        logic [31:0]         rel;
        logic                sdone;
        int                  sel;
        foreach (task_used[s]) begin
            task_used[s] = 1'b0;
            task_tbl[s]  = '0;
        end

        // empty table
        task_ops_q.push_back(sched_op(edfts_pkg::OP_PICK, 8'h00, '0, '0, 8'h00, 1'b0, 32'd0));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_RELEASE, 8'h00, '0, '0, 8'h00, 1'b0,
                                      32'd0));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_MARK_DONE, 8'd77, '0, '0, 8'h00, 1'b0,
                                      32'd0));

        // all-zero and all-ones entries
        task_ops_q.push_back(sched_op(edfts_pkg::OP_REGISTER, 8'h00, '0, '0, 8'h00, 1'b0, '0));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_REGISTER, 8'hff, '1, '1, 8'hff, 1'b1, '1));
        known_ids.push_back(8'h00);
        known_ids.push_back(8'hff);
        task_ops_q.push_back(sched_op(edfts_pkg::OP_PICK, 8'h00, '0, '0, 8'h00, 1'b0, 32'd0));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_RELEASE, 8'h00, '0, '0, 8'h00, 1'b0,
                                      32'hffff_fffe));

        // fill the table, duplicate ids, slots 2 and 3 share a deadline
        for (int k = 2; k < edfts_pkg::MAX_TASKS; k++) begin
            per   = (k < 4) ? 32'd5 : $urandom_range(10, 300);
            rel   = (k < 4) ? 32'd0 : $urandom_range(0, 100);
            sdone = (k >= 6) && k[0];
            known_ids.push_back(8'((k % 5) + 1));
            task_ops_q.push_back(sched_op(edfts_pkg::OP_REGISTER, 8'((k % 5) + 1), per, rel,
                                          8'($urandom_range(1, 254)), sdone, $urandom));
        end
        task_ops_q.push_back(sched_op(edfts_pkg::OP_PICK, 8'h00, '0, '0, 8'h00, 1'b0, 32'd5));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_REGISTER, 8'($urandom), $urandom,
                                      $urandom, 8'($urandom), 1'($urandom), $urandom));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_MARK_DONE, 8'd3, '0, '0, 8'h00, 1'b0, '0));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_RELEASE, 8'h00, '0, '0, 8'h00, 1'b0,
                                      32'd150));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_PICK, 8'h00, '0, '0, 8'h00, 1'b0,
                                      32'd150));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_MARK_DONE, 8'hff, '0, '0, 8'h00, 1'b0,
                                      '0));
        task_ops_q.push_back(sched_op(edfts_pkg::OP_PICK, 8'h00, '0, '0, 8'h00, 1'b0,
                                      32'hffff_ffff));

        // random traffic on an advancing tick, unused fields carry noise
        tick = 32'd200;
        repeat (RANDOM_OPS) begin
            tick += $urandom_range(0, 24);
            if ($urandom_range(99) < 2)
                tick += $urandom;
            op  = sched_op(edfts_pkg::OP_REGISTER, 8'($urandom), $urandom, $urandom,
                           8'($urandom), 1'($urandom), tick);
            sel = $urandom_range(99);
            if (sel < 5) begin
                op.operation = edfts_pkg::OP_REGISTER;
            end else if (sel < 35) begin
                op.operation = edfts_pkg::OP_MARK_DONE;
                if ($urandom_range(99) < 85)
                    op.task_id = known_ids[$urandom_range(known_ids.size() - 1)];
            end else if (sel < 65) begin
                op.operation = edfts_pkg::OP_RELEASE;
            end else begin
                op.operation = edfts_pkg::OP_PICK;
            end
            task_ops_q.push_back(op);
        end
        total_ops = task_ops_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted != total_ops || sched_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== edf_task_table_scheduler.f =====
sv/edfts_pkg.sv
sv/edfts_ram.sv
sv/edfts_engine.sv
sv/edf_task_table_scheduler.sv
dv/edf_task_table_scheduler_tb.sv
